@@ rtl/vtnl_pkg.sv @@
// Package for the value table with nearest lookup.
// Holds the function codes, field widths and the min/max reset values.
// No dependencies.
`default_nettype none

package vtnl_pkg;

  // Default number of table entries
  localparam int unsigned DEPTH_DEF = 256;

  // Field widths
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned FUNC_W = 2;

  // Reset values of the running minimum and maximum
  localparam logic signed [VAL_W-1:0] MOST_POS = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] MOST_NEG = {1'b1, {(VAL_W-1){1'b0}}};

  // Function codes carried by each input item
  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_CHANGE = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_LOOKUP = 2'd3
  } func_e;

endpackage

`default_nettype wire

@@ rtl/vtnl_if.sv @@
// Valid/ready channel interfaces of the value table: input items and results.
// Depends on vtnl_pkg.
`default_nettype none

// Input item channel
interface vtnl_in_if import vtnl_pkg::*;;
  logic                    valid;
  logic                    ready;
  func_e                   func;
  logic signed [IDX_W-1:0] index;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output func, output index, output value, input ready);
  modport sink   (input valid, input func, input index, input value, output ready);
endinterface

// Result item channel; CNT_W follows the table depth
interface vtnl_out_if import vtnl_pkg::*; #(
  parameter int unsigned CNT_W = $clog2(DEPTH_DEF + 1)
);
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] result_value;
  logic [CNT_W-1:0]        entry_count;
  logic signed [VAL_W-1:0] min_value;
  logic signed [VAL_W-1:0] max_value;
  logic                    dropped;
  logic                    was_empty;

  modport source (output valid, output result_value, output entry_count, output min_value,
                  output max_value, output dropped, output was_empty, input ready);
  modport sink   (input valid, input result_value, input entry_count, input min_value,
                  input max_value, input dropped, input was_empty, output ready);
endinterface

`default_nettype wire

@@ rtl/vtnl_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module vtnl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/value_table_nearest_lookup.sv @@
// Value table with nearest lookup: entries held in order, with running min and max.
// Channels: in_i takes an item (func, index, value) when valid and ready are high;
// out_o gives one result per item (result_value, entry_count, min_value,
// max_value, dropped, was_empty) under the same valid/ready rule.
// Items are worked one at a time. An item is taken only while the control is
// idle, even if the previous result is still waiting in the output register.
// Append, or any item on an empty table, goes from idle straight to the done
// state; read goes through the read state; a lookup at or above the last entry
// ends there, else it scans on; change rewrites the entry and rescans min and max.
// The long cases walk the entry memory through its single read port, one
// entry per cycle.
// When the receiver stalls, a finished result waits in the done state until
// the output register is free; the block then returns to idle.
// Reset empties the table: count 0, min at the most positive value and max at
// the most negative value. The memory needs no clearing, as only entries
// below the count are read.
// Depends on vtnl_pkg, vtnl_if and vtnl_ram.
`default_nettype none

module value_table_nearest_lookup import vtnl_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  vtnl_in_if.sink    in_i,
  vtnl_out_if.source out_o
);

  localparam int unsigned CmpW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESCAN,
    ST_READ,
    ST_LAST,
    ST_NSCAN,
    ST_DONE
  } state_e;

  typedef logic signed [VAL_W-1:0] val_t;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] iss_q, iss_d;
  logic          rvld_q, rvld_d;
  logic          first_q, first_d;
  val_t          min_q, min_d, max_q, max_d;
  val_t          key_q, key_d, prev_q, prev_d, res_q, res_d;
  logic          drop_q, drop_d, empty_q, empty_d;

  logic          out_vld_q, out_vld_d;
  val_t          out_res_q, out_res_d, out_min_q, out_min_d, out_max_q, out_max_d;
  logic [CW-1:0] out_cnt_q, out_cnt_d;
  logic          out_drop_q, out_drop_d, out_empty_q, out_empty_d;

  // Memory port signals
  logic          we;
  logic [AW-1:0] waddr;
  logic          re;
  logic [AW-1:0] raddr;
  logic [VAL_W-1:0] rdata_raw;
  val_t          rdata;

  logic          in_acc;
  logic          out_free;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] last_addr;
  logic [CmpW-1:0] idx_ext, cnt_ext;
  logic [AW-1:0] clamp_addr;

  vtnl_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_i.value),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata = $signed(rdata_raw);

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;

  // Index clamp to 0..count-1
  assign cnt_m1    = cnt_q - CW'(1);
  assign last_addr = AW'(cnt_m1);
  assign idx_ext   = CmpW'(in_i.index[IDX_W-2:0]);
  assign cnt_ext   = CmpW'(cnt_q);

  always_comb begin
    if (in_i.index[IDX_W-1]) begin
      clamp_addr = '0;
    end else if (idx_ext >= cnt_ext) begin
      clamp_addr = last_addr;
    end else begin
      clamp_addr = AW'(idx_ext);
    end
  end

  // Control sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    iss_d       = iss_q;
    rvld_d      = 1'b0;
    first_d     = first_q;
    min_d       = min_q;
    max_d       = max_q;
    key_d       = key_q;
    prev_d      = prev_q;
    res_d       = res_q;
    drop_d      = drop_q;
    empty_d     = empty_q;
    out_vld_d   = out_vld_q && !out_o.ready;
    out_res_d   = out_res_q;
    out_cnt_d   = out_cnt_q;
    out_min_d   = out_min_q;
    out_max_d   = out_max_q;
    out_drop_d  = out_drop_q;
    out_empty_d = out_empty_q;
    we          = 1'b0;
    waddr       = AW'(cnt_q);
    re          = 1'b0;
    raddr       = AW'(iss_q);

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          key_d   = in_i.value;
          res_d   = '0;
          drop_d  = 1'b0;
          empty_d = 1'b0;
          state_d = ST_DONE;
          if (in_i.func == FUNC_APPEND) begin
            if (cnt_q < CW'(DEPTH)) begin
              we    = 1'b1;
              cnt_d = cnt_q + CW'(1);
              if (in_i.value < min_q) min_d = in_i.value;
              if (in_i.value > max_q) max_d = in_i.value;
            end else begin
              drop_d = 1'b1;
            end
          end else if (cnt_q == '0) begin
            empty_d = 1'b1;
          end else begin
            unique case (in_i.func)
              FUNC_CHANGE: begin
                we      = 1'b1;
                waddr   = clamp_addr;
                min_d   = MOST_POS;
                max_d   = MOST_NEG;
                iss_d   = '0;
                state_d = ST_RESCAN;
              end
              FUNC_READ: begin
                re      = 1'b1;
                raddr   = clamp_addr;
                state_d = ST_READ;
              end
              FUNC_LOOKUP: begin
                re      = 1'b1;
                raddr   = last_addr;
                state_d = ST_LAST;
              end
              default: begin
              end
            endcase
          end
        end
      end

      // Walk all entries, folding each returned word into min and max
      ST_RESCAN: begin
        if (iss_q != cnt_q) begin
          re     = 1'b1;
          iss_d  = iss_q + CW'(1);
          rvld_d = 1'b1;
        end
        if (rvld_q) begin
          if (rdata < min_q) min_d = rdata;
          if (rdata > max_q) max_d = rdata;
        end
        if (iss_q == cnt_q && !rvld_q) begin
          state_d = ST_DONE;
        end
      end

      ST_READ: begin
        res_d   = rdata;
        state_d = ST_DONE;
      end

      // Last entry returned: at or above it ends the lookup, else scan from 0
      ST_LAST: begin
        if (key_q >= rdata) begin
          res_d   = rdata;
          state_d = ST_DONE;
        end else begin
          iss_d   = '0;
          first_d = 1'b1;
          state_d = ST_NSCAN;
        end
      end

      // Scan until an equal or a larger entry; a larger one always exists
      ST_NSCAN: begin
        if (iss_q != cnt_q) begin
          re     = 1'b1;
          iss_d  = iss_q + CW'(1);
          rvld_d = 1'b1;
        end
        if (rvld_q) begin
          if (key_q == rdata) begin
            res_d   = key_q;
            rvld_d  = 1'b0;
            state_d = ST_DONE;
          end else if (key_q < rdata) begin
            res_d   = first_q ? rdata : prev_q;
            rvld_d  = 1'b0;
            state_d = ST_DONE;
          end else begin
            prev_d  = rdata;
            first_d = 1'b0;
          end
        end
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_res_d   = res_q;
          out_cnt_d   = cnt_q;
          out_min_d   = min_q;
          out_max_d   = max_q;
          out_drop_d  = drop_q;
          out_empty_d = empty_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      iss_q       <= '0;
      rvld_q      <= 1'b0;
      first_q     <= 1'b0;
      min_q       <= MOST_POS;
      max_q       <= MOST_NEG;
      out_vld_q   <= 1'b0;
      key_q       <= '0;
      prev_q      <= '0;
      res_q       <= '0;
      drop_q      <= 1'b0;
      empty_q     <= 1'b0;
      out_res_q   <= '0;
      out_cnt_q   <= '0;
      out_min_q   <= '0;
      out_max_q   <= '0;
      out_drop_q  <= 1'b0;
      out_empty_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      iss_q       <= iss_d;
      rvld_q      <= rvld_d;
      first_q     <= first_d;
      min_q       <= min_d;
      max_q       <= max_d;
      out_vld_q   <= out_vld_d;
      key_q       <= key_d;
      prev_q      <= prev_d;
      res_q       <= res_d;
      drop_q      <= drop_d;
      empty_q     <= empty_d;
      out_res_q   <= out_res_d;
      out_cnt_q   <= out_cnt_d;
      out_min_q   <= out_min_d;
      out_max_q   <= out_max_d;
      out_drop_q  <= out_drop_d;
      out_empty_q <= out_empty_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.result_value = out_res_q;
  assign out_o.entry_count  = out_cnt_q;
  assign out_o.min_value    = out_min_q;
  assign out_o.max_value    = out_max_q;
  assign out_o.dropped      = out_drop_q;
  assign out_o.was_empty    = out_empty_q;

`ifndef SYNTHESIS
  // The fill count never passes the table depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  // An append into a table with room grows the count by one
  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.func == FUNC_APPEND && cnt_q < CW'(DEPTH) |=>
      cnt_q == $past(cnt_q) + CW'(1))
    else $error("append did not grow the count");

  // The memory is written only when an item is taken
  a_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> in_acc)
    else $error("memory written outside item acceptance");

  // Scan reads stay below the fill count
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    re && (state_q == ST_RESCAN || state_q == ST_NSCAN) |-> iss_q < cnt_q)
    else $error("scan read beyond held entries");

  // Between items, a non-empty table has min not above max
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE && cnt_q != '0 |-> min_q <= max_q)
    else $error("running min above running max");
`endif

endmodule

`default_nettype wire
